FILE: rtl/fsoc_pkg.sv
`timescale 1ns / 1ps

package fsoc_pkg;

    // field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int OVF_W   = 15;
    localparam int EXP_W   = 16;
    localparam int FRAME_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // saturation limits
    localparam logic [OVF_W-1:0] OVF_MAX = '1;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    // reset values of the configuration registers
    localparam logic [VALUE_W-1:0] OVF_LEVEL_RST   = 32'd65535;
    localparam logic [FRAME_W-1:0] FRAME_PIXEL_RST = 17'd65536;

    // item modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS   = 2'd1;

    // one entry of the frame stores
    typedef struct packed {
        logic [VALUE_W-1:0] sum;
        logic [OVF_W-1:0]   ovf;
    } t_store_data;

endpackage

FILE: rtl/fsoc_store.sv
`timescale 1ns / 1ps

module fsoc_store
    import fsoc_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output t_store_data       o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  t_store_data       i_wr_data
);

    logic [VALUE_W-1:0] r_sum_mem [DEPTH];
    logic [OVF_W-1:0]   r_ovf_mem [DEPTH];
    t_store_data        r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sum_mem[i_wr_addr] <= i_wr_data.sum;
            r_ovf_mem[i_wr_addr] <= i_wr_data.ovf;
        end
    end

    // read with bypass of a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data.sum <= r_sum_mem[i_rd_addr];
                r_rd_data.ovf <= r_ovf_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/frame_sum_with_overflow_count_unit.sv
`timescale 1ns / 1ps
// a result is offered from the output register after its transaction has passed stage 1
// throughput: one pixel per cycle unless stalled, set by the single read-modify-write of the stores
// a write that lands on the entry read in the same cycle is bypassed into the read data
// reset: position, exposure total, pipeline valids and the configuration registers
// return to their defaults; the frame stores keep their contents and need no clearing pass
module frame_sum_with_overflow_count_unit
    import fsoc_pkg::*;
#(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [VALUE_W-1:0]    i_pixel_value,
    input  logic [EXP_W-1:0]      i_source_exposures,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_W-1:0]    o_accumulated_value,
    output logic [OVF_W-1:0]      o_overflow_count,
    output logic [EXP_W-1:0]      o_frames_summed,
    output logic                  o_frame_done,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // position width and the width used for frame size compares
    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = (PW + 1 > FRAME_W) ? PW + 1 : FRAME_W;
    localparam logic [CW-1:0] MAX_FRAME = CW'(MAX_PIXELS);

    // configuration registers
    logic [VALUE_W-1:0] r_ovf_level;
    logic [FRAME_W-1:0] r_frame_pixels;

    // frame position and exposure total
    logic [PW-1:0]      r_pos;
    logic [EXP_W-1:0]   r_exp_total;

    // stage 1: item waiting on its store read
    logic               r_s1_valid;
    logic               r_s1_clear;
    logic               r_s1_first;
    logic               r_s1_over;
    logic               r_s1_last;
    logic [VALUE_W-1:0] r_s1_val;
    logic [PW-1:0]      r_s1_addr;
    logic [EXP_W-1:0]   r_s1_total;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_sum;
    logic [OVF_W-1:0]   r_out_ovf;
    logic [EXP_W-1:0]   r_out_total;
    logic               r_out_last;

    // stage 0 decode
    logic               in_accept;
    logic               s1_adv;
    logic [CW-1:0]      frame_eff;
    logic [CW-1:0]      pos_plus;
    logic               last;
    logic [EXP_W:0]     exp_sum;
    logic [EXP_W-1:0]   n_exp_total;
    logic [PW-1:0]      n_pos;

    // stage 1 compute
    t_store_data        rd_data;
    t_store_data        wr_data;
    logic               wr_en;

    assign o_cfg_ready = 1'b1;

    // the output register frees stage 1 whenever it is empty or being drained
    assign s1_adv    = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !s1_adv;
    assign in_accept = i_valid && !o_stall;

    // clamp frame size to one pixel at least and to the store depth at most
    always_comb begin
        frame_eff = CW'(r_frame_pixels);
        if (r_frame_pixels == '0) begin
            frame_eff = CW'(1);
        end else if (frame_eff > MAX_FRAME) begin
            frame_eff = MAX_FRAME;
        end
    end

    // a position at or past the frame end closes the frame
    assign pos_plus = CW'(r_pos) + CW'(1);
    assign last     = (pos_plus >= frame_eff);
    assign n_pos    = last ? '0 : pos_plus[PW-1:0];

    // exposure total saturates
    assign exp_sum     = {1'b0, r_exp_total} + {1'b0, i_source_exposures};
    assign n_exp_total = last ? (exp_sum[EXP_W] ? EXP_MAX : exp_sum[EXP_W-1:0]) : r_exp_total;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_level    <= OVF_LEVEL_RST;
            r_frame_pixels <= FRAME_PIXEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_OVERFLOW_LEVEL) begin
                r_ovf_level <= i_cfg_data;
            end else if (i_cfg_index == CFG_FRAME_PIXELS) begin
                r_frame_pixels <= i_cfg_data[FRAME_W-1:0];
            end
        end
    end

    // position and exposure total advance as soon as the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_exp_total <= '0;
        end else if (in_accept) begin
            if (i_mode == MODE_CLEAR) begin
                r_pos       <= '0;
                r_exp_total <= '0;
            end else begin
                r_pos       <= n_pos;
                r_exp_total <= n_exp_total;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_clear <= (i_mode == MODE_CLEAR);
            r_s1_first <= (r_exp_total == '0);
            r_s1_over  <= (i_pixel_value > r_ovf_level);
            r_s1_last  <= last;
            r_s1_val   <= i_pixel_value;
            r_s1_addr  <= r_pos;
            r_s1_total <= n_exp_total;
        end
    end

    // first frame overwrites, later frames add and count
    always_comb begin
        if (r_s1_first) begin
            wr_data.sum = r_s1_val;
            wr_data.ovf = OVF_W'(r_s1_over);
        end else begin
            wr_data.sum = rd_data.sum + r_s1_val;
            wr_data.ovf = rd_data.ovf;
            if (r_s1_over && (rd_data.ovf != OVF_MAX)) begin
                wr_data.ovf = rd_data.ovf + OVF_W'(1);
            end
        end
    end

    // write back as the item moves to the output register
    assign wr_en = r_s1_valid && !r_s1_clear && s1_adv;

    fsoc_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept && (i_mode == MODE_ACCUM)),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload, a clear returns all zeros
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            if (r_s1_clear) begin
                r_out_sum   <= '0;
                r_out_ovf   <= '0;
                r_out_total <= '0;
                r_out_last  <= 1'b0;
            end else begin
                r_out_sum   <= wr_data.sum;
                r_out_ovf   <= wr_data.ovf;
                r_out_total <= r_s1_total;
                r_out_last  <= r_s1_last;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_accumulated_value = r_out_sum;
    assign o_overflow_count    = r_out_ovf;
    assign o_frames_summed     = r_out_total;
    assign o_frame_done        = r_out_last;

endmodule

FILE: rtl/fsoc_checker.sv
`timescale 1ns / 1ps

module fsoc_checker
    import fsoc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [OVF_W-1:0]      o_overflow_count,
    input  logic [EXP_W-1:0]      o_frames_summed
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // backpressure only passes upstream when the output itself is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with output free");

    // within the first frame a pixel count is at most one
    a_first_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frames_summed == '0) |-> (o_overflow_count <= OVF_W'(1)))
        else $error("overflow count above one before any frame summed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind frame_sum_with_overflow_count_unit fsoc_checker u_fsoc_checker (.*);
